FILE: rtl/oale_pkg.sv
// ----------------------------------------------------------------------------
// oale_pkg
// shared types and constants for the ordered array list engine
// ----------------------------------------------------------------------------
package oale_pkg;

  // default list capacity
  localparam int DEPTH_DEF = 16;

  // fixed field widths
  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int WORD_W   = 32;
  localparam int STAT_W   = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int IN_DW    = 40;
  localparam int OUT_DW   = 48;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INS_AT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_HEAD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_APPEND   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MODIFY   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd6;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_INS_WR,
    S_FIND,
    S_RD_WAIT,
    S_OUT
  } state_t;

endpackage

FILE: rtl/oale_ram.sv
// ----------------------------------------------------------------------------
// oale_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// bounded list of 32-bit words with insert, delete, find, modify and read
// ----------------------------------------------------------------------------
// usage:
//   one operation per input transfer on the in_ stream, one result per
//   operation on the out_ stream. entries live in a single ram with one
//   write and one registered read port; a small sequencer walks the ram one
//   entry per cycle through a shared read/compare/write path.
// steps per operation, n = entries before the operation:
//   insert at p : entries p..n-1 move up one slot, top first, then the value is written at p
//   delete at p : entries p+1..n-1 move down one slot, lowest first
//   find        : scans from entry 0, stops at the first match
//   read        : the entry is fetched through the registered read port; modify,
//   errors and unused kinds go straight to the result; moves and scans are paced
//   by the single ram port pair that moves one entry per cycle
// in_tready is high only while no operation is in flight; the next item is
//   taken the cycle after the result transfer completes
// a stalled receiver holds the result in out_tdata and blocks new input
// reset (rst_n low, synchronous) empties the list; ram contents are not
//   cleared, only entries below the count are ever read
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
  parameter int DEPTH = oale_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: kind[2:0], position[7:3], value[39:8]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [oale_pkg::IN_DW-1:0]  in_tdata,
  // out_tdata: status[1:0], found_index[5:2], read_value[37:6], count[42:38],
  //            zero fill [47:43]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [oale_pkg::OUT_DW-1:0] out_tdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

  // input field split
  logic [oale_pkg::KIND_W-1:0] kind;
  logic [oale_pkg::POS_W-1:0]  pos_in;
  logic [oale_pkg::WORD_W-1:0] val_in;

  assign kind   = in_tdata[2:0];
  assign pos_in = in_tdata[7:3];
  assign val_in = in_tdata[39:8];

  // registers
  oale_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic [AW-1:0]                ptr_r, ptr_nxt;
  logic [AW-1:0]                pos_r, pos_nxt;
  logic [AW-1:0]                pend_addr_r, pend_addr_nxt;
  logic                         pend_r, pend_nxt;
  logic                         issue_done_r, issue_done_nxt;
  logic                         up_r, up_nxt;
  logic [oale_pkg::WORD_W-1:0]  val_r, val_nxt;
  logic [oale_pkg::STAT_W-1:0]  status_r, status_nxt;
  logic [oale_pkg::FOUND_W-1:0] found_r, found_nxt;
  logic [oale_pkg::WORD_W-1:0]  read_r, read_nxt;

  // ram port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [oale_pkg::WORD_W-1:0]  ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [oale_pkg::WORD_W-1:0]  ram_rdata;

  oale_ram #(
    .WIDTH (oale_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // handshake
  logic accept;
  assign in_tready  = (state_r == oale_pkg::S_IDLE);
  assign out_tvalid = (state_r == oale_pkg::S_OUT);
  assign accept     = in_tvalid & in_tready;

  // position checks, all in one common width
  logic [CMPW-1:0] pos_x, cnt_x, ins_pos_x;
  logic            is_insert, ins_bad, full, ins_shift, idx_ok, del_shift;

  assign pos_x     = CMPW'(pos_in);
  assign cnt_x     = CMPW'(count_r);
  assign is_insert = (kind == oale_pkg::KIND_INS_AT) || (kind == oale_pkg::KIND_INS_HEAD) ||
                     (kind == oale_pkg::KIND_APPEND);
  assign ins_pos_x = (kind == oale_pkg::KIND_INS_AT)   ? pos_x :
                     (kind == oale_pkg::KIND_INS_HEAD) ? '0 : cnt_x;
  assign ins_bad   = ins_pos_x > cnt_x;
  assign full      = (count_r == CW'(DEPTH));
  assign ins_shift = cnt_x > ins_pos_x;
  assign idx_ok    = pos_x < cnt_x;
  assign del_shift = (pos_x + CMPW'(1)) < cnt_x;

  // sequencer conditions
  logic [AW-1:0] last_addr;
  logic [AW-1:0] shift_end;
  logic          last_issue;
  logic          hit;

  assign last_addr  = AW'(count_r - CW'(1));
  assign shift_end  = up_r ? pos_r : last_addr;
  assign last_issue = (ptr_r == ((state_r == oale_pkg::S_FIND) ? last_addr : shift_end));
  assign hit        = pend_r && (ram_rdata == val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oale_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = oale_pkg::S_OUT;
          if (is_insert) begin
            if (!ins_bad && !full) begin
              state_nxt = ins_shift ? oale_pkg::S_SHIFT : oale_pkg::S_INS_WR;
            end
          end else if (kind == oale_pkg::KIND_DELETE) begin
            if (idx_ok && del_shift) begin
              state_nxt = oale_pkg::S_SHIFT;
            end
          end else if (kind == oale_pkg::KIND_FIND) begin
            if (count_r != '0) begin
              state_nxt = oale_pkg::S_FIND;
            end
          end else if (kind == oale_pkg::KIND_READ) begin
            if (idx_ok) begin
              state_nxt = oale_pkg::S_RD_WAIT;
            end
          end
        end
      end
      oale_pkg::S_SHIFT: begin
        if (issue_done_r) begin
          state_nxt = up_r ? oale_pkg::S_INS_WR : oale_pkg::S_OUT;
        end
      end
      oale_pkg::S_INS_WR:  state_nxt = oale_pkg::S_OUT;
      oale_pkg::S_FIND: begin
        if (hit || issue_done_r) begin
          state_nxt = oale_pkg::S_OUT;
        end
      end
      oale_pkg::S_RD_WAIT: state_nxt = oale_pkg::S_OUT;
      oale_pkg::S_OUT: begin
        if (out_tready) begin
          state_nxt = oale_pkg::S_IDLE;
        end
      end
      default:             state_nxt = oale_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    pend_addr_nxt  = pend_addr_r;
    pend_nxt       = pend_r;
    issue_done_nxt = issue_done_r;
    up_nxt         = up_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    read_nxt       = read_r;
    ram_we         = 1'b0;
    ram_waddr      = pend_addr_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r;

    case (state_r)
      oale_pkg::S_IDLE: begin
        ram_raddr = AW'(pos_in);
        if (accept) begin
          status_nxt     = oale_pkg::STAT_OK;
          found_nxt      = '0;
          read_nxt       = '0;
          pend_nxt       = 1'b0;
          issue_done_nxt = 1'b0;
          val_nxt        = val_in;
          if (is_insert) begin
            up_nxt  = 1'b1;
            pos_nxt = AW'(ins_pos_x);
            ptr_nxt = last_addr;
            if (ins_bad) begin
              status_nxt = oale_pkg::STAT_BADPOS;
            end else if (full) begin
              status_nxt = oale_pkg::STAT_FULL;
            end
          end else if (kind == oale_pkg::KIND_DELETE) begin
            up_nxt  = 1'b0;
            ptr_nxt = AW'(pos_x + CMPW'(1));
            if (!idx_ok) begin
              status_nxt = oale_pkg::STAT_BADPOS;
            end else if (!del_shift) begin
              // removing the last entry moves nothing
              count_nxt = count_r - CW'(1);
            end
          end else if (kind == oale_pkg::KIND_FIND) begin
            ptr_nxt = '0;
            if (count_r == '0) begin
              status_nxt = oale_pkg::STAT_NOTFOUND;
            end
          end else if (kind == oale_pkg::KIND_MODIFY) begin
            if (idx_ok) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(pos_in);
              ram_wdata = val_in;
            end else begin
              status_nxt = oale_pkg::STAT_BADPOS;
            end
          end else if (kind == oale_pkg::KIND_READ) begin
            if (!idx_ok) begin
              status_nxt = oale_pkg::STAT_BADPOS;
            end
          end
        end
      end
      oale_pkg::S_SHIFT: begin
        // read one entry ahead, write the previous read one slot over
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (issue_done_r) begin
          pend_nxt = 1'b0;
          if (!up_r) begin
            count_nxt = count_r - CW'(1);
          end
        end else begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = up_r ? (ptr_r + AW'(1)) : (ptr_r - AW'(1));
          if (last_issue) begin
            issue_done_nxt = 1'b1;
          end else begin
            ptr_nxt = up_r ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
          end
        end
      end
      oale_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
      end
      oale_pkg::S_FIND: begin
        // compare the word read last cycle while the next one is fetched
        if (hit) begin
          found_nxt = oale_pkg::FOUND_W'(pend_addr_r);
        end else if (issue_done_r) begin
          status_nxt = oale_pkg::STAT_NOTFOUND;
        end
        if (!issue_done_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          if (last_issue) begin
            issue_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + AW'(1);
          end
        end
      end
      oale_pkg::S_RD_WAIT: begin
        read_nxt = ram_rdata;
      end
      oale_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= oale_pkg::S_IDLE;
      count_r      <= '0;
      pend_r       <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      issue_done_r <= issue_done_nxt;
    end
  end

  // payload and pointers
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
    up_r        <= up_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    read_r      <= read_nxt;
  end

  // result packing
  assign out_tdata = {5'd0, oale_pkg::COUNT_W'(count_r), read_r, found_r, status_r};

endmodule
